/* hdl/pmtd_pkg.sv */
// Shared types, codes and sizing functions of the telemetry word decoder.
package pmtd_pkg;

	// Field and register widths
	localparam int RAW_W         = 16;
	localparam int MODE_W        = 3;
	localparam int VALUE_W       = 42;
	localparam int STATUS_W      = 2;
	localparam int GAIN_W        = 10;
	localparam int OFFSET_W      = 16;
	localparam int SLOPE_W       = 15;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	// |raw*gain - offset| stays below 2^26
	localparam int NUM_MAG_W     = 26;
	// quotient bits resolved per divider stage
	localparam int DIV_STEP_BITS = 4;
	localparam int FRONT_STAGES  = 3;
	// LINEAR11 shift amount, signed
	localparam int LIN_SH_W      = 7;

	// Conversion modes
	localparam logic [MODE_W-1:0] MODE_LIN8   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LIN9   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LIN11  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LIN2   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TEMP   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_VIN    = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD6  = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD7  = 3'd7;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNSUP = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SLOPE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VIN_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VIN_SLOPE   = 3'd4;

	// Register reset values
	localparam logic [GAIN_W-1:0]          RST_TEMP_GAIN   = 10'd10;
	localparam logic signed [OFFSET_W-1:0] RST_TEMP_OFFSET = 16'sd5887;
	localparam logic [SLOPE_W-1:0]         RST_TEMP_SLOPE  = 15'd21;
	localparam logic [GAIN_W-1:0]          RST_VIN_GAIN    = 10'd100;
	localparam logic [SLOPE_W-1:0]         RST_VIN_SLOPE   = 15'd3609;

	// Saturation bounds of the value field
	localparam logic [VALUE_W-1:0] VAL_POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VAL_NEG_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef struct packed {
		logic [RAW_W-1:0]  raw_word;
		logic [MODE_W-1:0] mode;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [STATUS_W-1:0]       status;
	} rsp_t;

	// Control that travels with each item down the pipeline
	typedef struct packed {
		logic              valid;
		logic [MODE_W-1:0] mode;
		logic              neg;
		logic              slope_zero;
		logic              dvd_zero;
	} ctl_t;

	// Magnitude width before saturation
	function automatic int mag_width(int fb);
		return NUM_MAG_W + fb;
	endfunction

	// Dividend width, padded to whole divider stages
	function automatic int div_width(int fb);
		return ((mag_width(fb) + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
	endfunction

	function automatic int div_stages(int fb);
		return div_width(fb) / DIV_STEP_BITS;
	endfunction

	// Cycles from request accept to result strobe
	function automatic int pipe_latency(int fb);
		return FRONT_STAGES + div_stages(fb) + 1;
	endfunction

endpackage

/* hdl/pmbus_telemetry_word_decoder_top.sv */
// Top level of the telemetry word decoder: config registers and the decode pipeline.
//
//  channel   signals                          direction  accepted when
//  request   start, busy, cmd                 in         start && !busy at clk rise
//  result    done, rsp                        out        done high, one cycle each
//  config    cfg_valid, cfg_ready, cfg_index,  in         cfg_valid && cfg_ready
//            cfg_data
//
// One request enters per cycle; busy stays low. Each item passes the front stages,
// then the stages of the restoring divider that resolves four quotient bits per stage,
// then the output register.
// Reset clears the valid bits of every stage and loads the coefficient defaults.
// The receiver cannot stall, so the pipeline only ever advances.
module pmbus_telemetry_word_decoder_top #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  pmtd_pkg::cmd_t                  cmd,
	output logic                            busy,
	output logic                            done,
	output pmtd_pkg::rsp_t                  rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pmtd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmtd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pmtd_pkg::*;

	localparam int MAG_W = mag_width(FRACTION_BITS);
	localparam int DIV_W = div_width(FRACTION_BITS);
	localparam int NST   = div_stages(FRACTION_BITS);

	// Coefficient registers
	logic [GAIN_W-1:0]          temp_gain_q;
	logic signed [OFFSET_W-1:0] temp_offset_q;
	logic [SLOPE_W-1:0]         temp_slope_q;
	logic [GAIN_W-1:0]          vin_gain_q;
	logic [SLOPE_W-1:0]         vin_slope_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_gain_q   <= RST_TEMP_GAIN;
			temp_offset_q <= RST_TEMP_OFFSET;
			temp_slope_q  <= RST_TEMP_SLOPE;
			vin_gain_q    <= RST_VIN_GAIN;
			vin_slope_q   <= RST_VIN_SLOPE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TEMP_GAIN:   temp_gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_TEMP_OFFSET: temp_offset_q <= $signed(cfg_data[OFFSET_W-1:0]);
				CFG_TEMP_SLOPE:  temp_slope_q  <= cfg_data[SLOPE_W-1:0];
				CFG_VIN_GAIN:    vin_gain_q    <= cfg_data[GAIN_W-1:0];
				CFG_VIN_SLOPE:   vin_slope_q   <= cfg_data[SLOPE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage outputs; index 0 comes from the front stages
	ctl_t               stage_ctl   [NST+1];
	logic [DIV_W-1:0]   stage_dq    [NST+1];
	logic [SLOPE_W-1:0] stage_rem   [NST+1];
	logic [SLOPE_W-1:0] stage_slope [NST+1];

	assign stage_rem[0] = '0;

	pmtd_front #(
		.FRACTION_BITS(FRACTION_BITS),
		.MAG_W(MAG_W),
		.DIV_W(DIV_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(start && !busy),
		.cmd(cmd),
		.temp_gain(temp_gain_q),
		.temp_offset(temp_offset_q),
		.temp_slope(temp_slope_q),
		.vin_gain(vin_gain_q),
		.vin_slope(vin_slope_q),
		.ctl_s3(stage_ctl[0]),
		.dividend_s3(stage_dq[0]),
		.slope_s3(stage_slope[0])
	);

	// Divider chain
	for (genvar g = 0; g < NST; g++) begin : g_div
		pmtd_div_stage #(
			.DIV_W(DIV_W)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.in_ctl(stage_ctl[g]),
			.in_dq(stage_dq[g]),
			.in_rem(stage_rem[g]),
			.in_slope(stage_slope[g]),
			.ctl_s1(stage_ctl[g+1]),
			.dq_s1(stage_dq[g+1]),
			.rem_s1(stage_rem[g+1]),
			.slope_s1(stage_slope[g+1])
		);
	end

	// Quotient never exceeds the dividend for a nonzero slope, so its top padding bits are zero
	pmtd_emit #(
		.FRACTION_BITS(FRACTION_BITS),
		.MAG_W(MAG_W)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(stage_ctl[NST]),
		.quotient(stage_dq[NST][MAG_W-1:0]),
		.done_q(done),
		.rsp_q(rsp)
	);

endmodule

/* hdl/pmtd_front.sv */
// Front stages: capture, gain multiply and format shifts, numerator and dividend setup.
module pmtd_front #(
	parameter int FRACTION_BITS = 16,
	parameter int MAG_W         = pmtd_pkg::mag_width(FRACTION_BITS),
	parameter int DIV_W         = pmtd_pkg::div_width(FRACTION_BITS)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  pmtd_pkg::cmd_t                         cmd,
	input  logic [pmtd_pkg::GAIN_W-1:0]            temp_gain,
	input  logic signed [pmtd_pkg::OFFSET_W-1:0]   temp_offset,
	input  logic [pmtd_pkg::SLOPE_W-1:0]           temp_slope,
	input  logic [pmtd_pkg::GAIN_W-1:0]            vin_gain,
	input  logic [pmtd_pkg::SLOPE_W-1:0]           vin_slope,
	output pmtd_pkg::ctl_t                         ctl_s3,
	output logic [DIV_W-1:0]                       dividend_s3,
	output logic [pmtd_pkg::SLOPE_W-1:0]           slope_s3
);
	import pmtd_pkg::*;

	localparam int L8 = FRACTION_BITS - 8;
	localparam int L9 = (FRACTION_BITS >= 9) ? FRACTION_BITS - 9 : 0;
	localparam int R9 = (FRACTION_BITS >= 9) ? 0 : 9 - FRACTION_BITS;
	localparam int L2 = FRACTION_BITS - 2;
	localparam int NUM_W = NUM_MAG_W + 2;

	// Stage 1: request capture
	logic valid_s1;
	cmd_t cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
	end

	// Stage 2: gain product and shifted magnitude of the linear formats
	logic [GAIN_W-1:0]          gain_sel;
	logic [NUM_MAG_W-1:0]       prod;
	logic [4:0]                 lin_exp;
	logic signed [LIN_SH_W-1:0] lin_sh;
	logic [10:0]                lin_mag;
	logic                       lin_neg;
	logic [5:0]                 lin_shl;
	logic [5:0]                 lin_shr;
	logic [LIN_SH_W-1:0]        lin_sh_neg;
	logic [MAG_W-1:0]           shmag;

	assign gain_sel = (cmd_s1.mode == MODE_VIN) ? vin_gain : temp_gain;
	assign prod     = NUM_MAG_W'(cmd_s1.raw_word) * NUM_MAG_W'(gain_sel);

	assign lin_exp    = cmd_s1.raw_word[15:11];
	assign lin_sh     = $signed({{(LIN_SH_W-5){lin_exp[4]}}, lin_exp}) +
	                    $signed(LIN_SH_W'(FRACTION_BITS));
	assign lin_neg    = cmd_s1.raw_word[10];
	assign lin_mag    = lin_neg ? 11'(12'd2048 - {1'b0, cmd_s1.raw_word[10:0]})
	                            : cmd_s1.raw_word[10:0];
	assign lin_sh_neg = LIN_SH_W'(-lin_sh);
	assign lin_shl    = lin_sh[LIN_SH_W-1] ? 6'd0 : lin_sh[5:0];
	assign lin_shr    = lin_sh[LIN_SH_W-1] ? lin_sh_neg[5:0] : 6'd0;

	always_comb begin
		case (cmd_s1.mode)
			MODE_LIN8:  shmag = MAG_W'(cmd_s1.raw_word) << L8;
			MODE_LIN9:  shmag = (MAG_W'(cmd_s1.raw_word) << L9) >> R9;
			MODE_LIN11: shmag = (MAG_W'(lin_mag) << lin_shl) >> lin_shr;
			MODE_LIN2:  shmag = MAG_W'(cmd_s1.raw_word[10:0]) << L2;
			default:    shmag = '0;
		endcase
	end

	logic                 valid_s2;
	logic [MODE_W-1:0]    mode_s2;
	logic [NUM_MAG_W-1:0] prod_s2;
	logic [MAG_W-1:0]     shmag_s2;
	logic                 neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2  <= cmd_s1.mode;
		prod_s2  <= prod;
		shmag_s2 <= shmag;
		neg_s2   <= (cmd_s1.mode == MODE_LIN11) && lin_neg;
	end

	// Stage 3: signed numerator, magnitude and divider operands
	logic signed [NUM_W-1:0] offs;
	logic signed [NUM_W-1:0] num;
	logic                    num_neg;
	logic [NUM_W-1:0]        num_abs;
	logic                    direct;
	logic [DIV_W-1:0]        dividend;
	logic [SLOPE_W-1:0]      slope;
	ctl_t                    ctl;

	assign offs    = (mode_s2 == MODE_TEMP) ?
	                 $signed({{(NUM_W-OFFSET_W){temp_offset[OFFSET_W-1]}}, temp_offset}) :
	                 $signed(NUM_W'(0));
	assign num     = $signed({2'b00, prod_s2}) - offs;
	assign num_neg = num[NUM_W-1];
	assign num_abs = num_neg ? NUM_W'(-num) : NUM_W'(num);
	assign direct  = (mode_s2 == MODE_TEMP) || (mode_s2 == MODE_VIN);

	// linear formats divide by one so every item takes the same path
	always_comb begin
		case (mode_s2)
			MODE_TEMP: slope = temp_slope;
			MODE_VIN:  slope = vin_slope;
			default:   slope = SLOPE_W'(1);
		endcase
	end

	assign dividend = direct ?
	                  DIV_W'({num_abs[NUM_MAG_W-1:0], {FRACTION_BITS{1'b0}}}) :
	                  DIV_W'(shmag_s2);

	always_comb begin
		ctl.valid      = valid_s2;
		ctl.mode       = mode_s2;
		ctl.neg        = direct ? num_neg : neg_s2;
		ctl.slope_zero = direct && (slope == '0);
		ctl.dvd_zero   = (dividend == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		dividend_s3 <= dividend;
		slope_s3    <= slope;
	end

endmodule

/* hdl/pmtd_div_stage.sv */
// One register stage of the restoring divider, DIV_STEP_BITS quotient bits per stage.
module pmtd_div_stage #(
	parameter int DIV_W = 44
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pmtd_pkg::ctl_t               in_ctl,
	input  logic [DIV_W-1:0]             in_dq,
	input  logic [pmtd_pkg::SLOPE_W-1:0] in_rem,
	input  logic [pmtd_pkg::SLOPE_W-1:0] in_slope,
	output pmtd_pkg::ctl_t               ctl_s1,
	output logic [DIV_W-1:0]             dq_s1,
	output logic [pmtd_pkg::SLOPE_W-1:0] rem_s1,
	output logic [pmtd_pkg::SLOPE_W-1:0] slope_s1
);
	import pmtd_pkg::*;

	logic [DIV_W-1:0]   dq_nxt;
	logic [SLOPE_W-1:0] rem_nxt;

	// dq holds unused dividend bits on top and fresh quotient bits below
	always_comb begin
		logic [SLOPE_W:0] trial;
		dq_nxt  = in_dq;
		rem_nxt = in_rem;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			trial = {rem_nxt, dq_nxt[DIV_W-1]};
			if (trial >= {1'b0, in_slope}) begin
				trial  = trial - {1'b0, in_slope};
				dq_nxt = {dq_nxt[DIV_W-2:0], 1'b1};
			end else begin
				dq_nxt = {dq_nxt[DIV_W-2:0], 1'b0};
			end
			rem_nxt = trial[SLOPE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		dq_s1    <= dq_nxt;
		rem_s1   <= rem_nxt;
		slope_s1 <= in_slope;
	end

endmodule

/* hdl/pmtd_emit.sv */
// Output stage: saturation, zero-slope and unsupported-mode handling, result register.
module pmtd_emit #(
	parameter int FRACTION_BITS = 16,
	parameter int MAG_W         = pmtd_pkg::mag_width(FRACTION_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pmtd_pkg::ctl_t   ctl,
	input  logic [MAG_W-1:0] quotient,
	output logic             done_q,
	output pmtd_pkg::rsp_t   rsp_q
);
	import pmtd_pkg::*;

	localparam int CW = (MAG_W > VALUE_W + 1) ? MAG_W : VALUE_W + 1;
	localparam logic [CW-1:0]      NEG_LIM   = CW'(1) << (VALUE_W - 1);
	localparam logic [CW-1:0]      POS_LIM   = NEG_LIM - CW'(1);
	localparam logic [VALUE_W-1:0] UNSUP_VAL = '0 - (VALUE_W'(1) << FRACTION_BITS);

	logic [CW-1:0] magx;
	logic [CW-1:0] mag_neg;
	rsp_t          rsp;

	assign magx    = CW'(quotient);
	assign mag_neg = CW'(-magx);

	// select and clamp the signed result
	always_comb begin
		rsp.status = ST_OK;
		rsp.value  = ctl.neg ? $signed(mag_neg[VALUE_W-1:0]) : $signed(magx[VALUE_W-1:0]);
		if ((ctl.mode == MODE_RSVD6) || (ctl.mode == MODE_RSVD7)) begin
			rsp.value  = $signed(UNSUP_VAL);
			rsp.status = ST_UNSUP;
		end else if (ctl.slope_zero) begin
			if (ctl.dvd_zero) begin
				rsp.value = '0;
			end else begin
				rsp.value  = ctl.neg ? $signed(VAL_NEG_MIN) : $signed(VAL_POS_MAX);
				rsp.status = ST_SAT;
			end
		end else if (!ctl.neg && (magx > POS_LIM)) begin
			rsp.value  = $signed(VAL_POS_MAX);
			rsp.status = ST_SAT;
		end else if (ctl.neg && (magx > NEG_LIM)) begin
			rsp.value  = $signed(VAL_NEG_MIN);
			rsp.status = ST_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp;
	end

endmodule

/* hdl/pmtd_checker.sv */
// Port-level assertions of the telemetry word decoder and their bind.
module pmtd_checker #(
	parameter int FRACTION_BITS = 16
) (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input pmtd_pkg::cmd_t cmd,
	input logic           done,
	input pmtd_pkg::rsp_t rsp
);
	import pmtd_pkg::*;

	localparam int LAT = pipe_latency(FRACTION_BITS);

	// every result strobe traces back to a request a fixed latency earlier
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching request");

	// every accepted request yields a strobe after the fixed latency
	a_request_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted request produced no result");

	// unsupported status only for the reserved modes
	a_unsup_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_UNSUP)) |->
		(($past(cmd.mode, LAT) == MODE_RSVD6) || ($past(cmd.mode, LAT) == MODE_RSVD7)))
		else $error("unsupported status for a supported mode");

	// only LINEAR11 and the direct modes can overflow the value field
	a_sat_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_SAT)) |->
		(($past(cmd.mode, LAT) == MODE_LIN11) || ($past(cmd.mode, LAT) == MODE_TEMP) ||
		 ($past(cmd.mode, LAT) == MODE_VIN)))
		else $error("saturation reported for a mode that cannot overflow");

endmodule

bind pmbus_telemetry_word_decoder_top pmtd_checker #(
	.FRACTION_BITS(FRACTION_BITS)
) u_pmtd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.cmd(cmd),
	.done(done),
	.rsp(rsp)
);
